// File: rtl/lcsmm_pkg.sv
// lcsmm_pkg: word types, command codes and job codes shared by the
// longest-common-subsequence marker. No dependencies.
`timescale 1ns / 1ps

package lcsmm_pkg;

    localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [1:0] CMD_COMPARE       = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] token;
    } t_in_word;

    typedef struct packed {
        logic [31:0] first_marks;
        logic [31:0] second_marks;
        logic [5:0]  common_length;
        logic        overflowed;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_APPEND_FIRST  = 2'd0,
        OP_APPEND_SECOND = 2'd1,
        OP_COMPARE       = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] token;
    } t_job;

endpackage

// File: rtl/lcsmm_front.sv
// lcsmm_front: accepts input words, drops unused commands and queues jobs
// in a two-entry queue for the back end. Uses lcsmm_pkg.
`timescale 1ns / 1ps

module lcsmm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcsmm_pkg::t_in_word i_in,
    output logic               o_full,
    output logic               o_job_valid,
    output lcsmm_pkg::t_job    o_job,
    input  logic               i_job_take
);
    import lcsmm_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       known;
    logic       wr, rd;
    t_job       job_in;

    always_comb begin
        known = 1'b1;
        job_in.token = i_in.token;
        case (i_in.cmd)
            CMD_APPEND_FIRST:  job_in.op = OP_APPEND_FIRST;
            CMD_APPEND_SECOND: job_in.op = OP_APPEND_SECOND;
            CMD_COMPARE:       job_in.op = OP_COMPARE;
            default: begin
                job_in.op = OP_COMPARE;
                known     = 1'b0;
            end
        endcase
    end

    assign o_full      = r_cnt[1];
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign wr          = i_push && !o_full && known;
    assign rd          = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// File: rtl/lcsmm_back.sv
// lcsmm_back: token storage, row-by-row LCS table, traceback and result
// register. Uses lcsmm_pkg.
`timescale 1ns / 1ps

module lcsmm_back #(
    parameter int MAX_LEN    = 32,
    parameter int TOKEN_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  lcsmm_pkg::t_job      i_job,
    output logic                 o_job_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output lcsmm_pkg::t_out_word o_out
);
    import lcsmm_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DD = 1 << (2 * IW);

    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROW    = 6'b000010,
        S_CELL   = 6'b000100,
        S_TB_RD  = 6'b001000,
        S_TB_STP = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_n1, r_n2, r_i, r_j, r_len, r_rem;
    logic                  r_ovf;
    logic [TOKEN_BITS-1:0] first_mem [MAX_LEN];
    logic [TOKEN_BITS-1:0] r_sec [MAX_LEN];
    logic [CW-1:0]         r_prev [MAX_LEN];
    logic [1:0]            dir_mem [DD];
    logic [TOKEN_BITS-1:0] r_a;
    logic [1:0]            r_dir;
    logic [CW-1:0]         r_diag, r_left;
    logic [31:0]           r_m1, r_m2;
    t_out_word             r_out;
    logic                  r_out_valid;

    logic [TOKEN_BITS-1:0] tok;
    logic [CW-1:0]         cell_len, n_len;
    logic [1:0]            cell_dir;
    logic [CW-1:0]         im1, jm1;
    logic [2*IW-1:0]       wr_addr, rd_addr;
    logic [31:0]           bit1, bit2;

    generate
        if (TOKEN_BITS <= 32) begin : g_narrow
            assign tok = i_job.token[TOKEN_BITS-1:0];
        end else begin : g_wide
            assign tok = TOKEN_BITS'(i_job.token);
        end
    endgenerate

    assign o_job_take = (r_state == S_IDLE);
    assign o_empty    = !r_out_valid;
    assign o_out      = r_out;

    always_comb begin
        if (r_a == r_sec[0]) begin
            cell_len = r_diag + 1'b1;
            cell_dir = DIR_DIAG;
        end else if (r_prev[0] >= r_left) begin
            cell_len = r_prev[0];
            cell_dir = DIR_UP;
        end else begin
            cell_len = r_left;
            cell_dir = DIR_LEFT;
        end
        n_len = (r_i == r_n1 && r_j == r_n2) ? cell_len : r_len;
        im1   = r_i - 1'b1;
        jm1   = r_j - 1'b1;
        wr_addr = {im1[IW-1:0], jm1[IW-1:0]};
        im1   = r_i - 1'b1;
        rd_addr = {im1[IW-1:0], jm1[IW-1:0]};
        // positions marked by a diagonal step, only the low 32 survive
        for (int k = 0; k < 32; k++) begin
            bit1[k] = (32'(im1) == k);
            bit2[k] = (32'(jm1) == k);
        end
    end

    // memories: clocked write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid && i_job.op == OP_APPEND_FIRST
            && r_n1 < CW'(MAX_LEN)) begin
            first_mem[r_n1[IW-1:0]] <= tok;
        end
        r_a <= first_mem[im1[IW-1:0]];
        if (r_state == S_CELL) begin
            dir_mem[wr_addr] <= cell_dir;
        end
        r_dir <= dir_mem[rd_addr];
    end

    // second sequence and previous row rotate one place per cell
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid && i_job.op == OP_APPEND_SECOND
            && r_n2 < CW'(MAX_LEN)) begin
            r_sec[r_n2[IW-1:0]] <= tok;
        end else if (r_state == S_CELL) begin
            for (int k = 0; k < MAX_LEN - 1; k++) begin
                r_sec[k] <= r_sec[k+1];
            end
            r_sec[MAX_LEN-1] <= r_sec[0];
        end
        if (r_state == S_IDLE) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                r_prev[k] <= '0;
            end
        end else if (r_state == S_CELL) begin
            for (int k = 0; k < MAX_LEN - 1; k++) begin
                r_prev[k] <= r_prev[k+1];
            end
            r_prev[MAX_LEN-1] <= cell_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n1        <= '0;
            r_n2        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        case (i_job.op)
                            OP_APPEND_FIRST: begin
                                if (r_n1 < CW'(MAX_LEN)) r_n1 <= r_n1 + 1'b1;
                                else r_ovf <= 1'b1;
                            end
                            OP_APPEND_SECOND: begin
                                if (r_n2 < CW'(MAX_LEN)) r_n2 <= r_n2 + 1'b1;
                                else r_ovf <= 1'b1;
                            end
                            default: begin
                                r_m1  <= '0;
                                r_m2  <= '0;
                                r_len <= '0;
                                r_i   <= CW'(1);
                                if (r_n1 == '0 || r_n2 == '0) r_state <= S_DONE;
                                else r_state <= S_ROW;
                            end
                        endcase
                    end
                end
                S_ROW: begin
                    r_diag  <= '0;
                    r_left  <= '0;
                    r_j     <= CW'(1);
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_len  <= n_len;
                    r_diag <= r_prev[0];
                    r_left <= cell_len;
                    if (r_j == CW'(MAX_LEN)) begin
                        if (r_i == r_n1) begin
                            r_i     <= r_n1;
                            r_j     <= r_n2;
                            r_rem   <= n_len;
                            r_state <= S_TB_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_TB_RD: begin
                    if (r_rem == '0) r_state <= S_DONE;
                    else r_state <= S_TB_STP;
                end
                S_TB_STP: begin
                    case (r_dir)
                        DIR_DIAG: begin
                            r_i   <= r_i - 1'b1;
                            r_j   <= r_j - 1'b1;
                            r_rem <= r_rem - 1'b1;
                            r_m1  <= r_m1 | bit1;
                            r_m2  <= r_m2 | bit2;
                        end
                        DIR_UP:  r_i <= r_i - 1'b1;
                        default: r_j <= r_j - 1'b1;
                    endcase
                    r_state <= S_TB_RD;
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_n1        <= '0;
                        r_n2        <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && !r_out_valid) begin
            r_out.first_marks   <= r_m1;
            r_out.second_marks  <= r_m2;
            r_out.common_length <= 6'(r_len);
            r_out.overflowed    <= r_ovf;
        end
    end

endmodule

// File: rtl/lcs_match_marker.sv
// lcs_match_marker: top level of the LCS matcher with traceback marks.
// Instantiates lcsmm_front and lcsmm_back; uses lcsmm_pkg.
`timescale 1ns / 1ps
//
//  channel | handshake        | word
//  --------+------------------+------------------------------------------
//  input   | i_push / o_full  | i_in  : cmd, token
//  result  | o_empty / i_pop  | o_out : marks, common_length, overflowed
//
//  Appends are taken while the back end is idle; the front queue holds two.
//  A compare builds the table row by row (one cell per cycle, rows always
//  sweep MAX_LEN columns), then walks the traceback through S_TB_RD and
//  S_TB_STP for each step, then loads the result register in S_DONE.
//  Synchronous active-low reset empties the queue, counts and result.
//  A full result register stalls the back end; the front keeps queueing.

module lcs_match_marker #(
    parameter int MAX_LEN    = 32,
    parameter int TOKEN_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lcsmm_pkg::t_in_word  i_in,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output lcsmm_pkg::t_out_word o_out
);
    import lcsmm_pkg::*;

    t_job job;
    logic job_valid, job_take;

    // front: classify and queue words
    lcsmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    // back: storage, table, traceback, result word
    lcsmm_back #(
        .MAX_LEN    (MAX_LEN),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

endmodule
